>>> design/drive_command_rate_limiter_core_assert.svh
// ----------------------------------------------------------------------------
// drive_command_rate_limiter_core_assert.svh
// Assertion macros used by the drive command rate limiter checker.
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_RATE_LIMITER_CORE_ASSERT_SVH
`define DRIVE_COMMAND_RATE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, off while rst_n is low.
`define DCRL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcrl: implication check failed");

// Next-cycle implication, off while rst_n is low.
`define DCRL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcrl: next-cycle check failed");

// Next-cycle implication that also covers the reset cycles.
`define DCRL_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dcrl: reset check failed");

`endif

>>> design/dcrl_pkg.sv
// ----------------------------------------------------------------------------
// dcrl_pkg
// Types, register indexes and reset values of the drive command rate limiter.
// ----------------------------------------------------------------------------
package dcrl_pkg;

  localparam int DELAY_DEPTH_DEF = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DECEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_DEADBAND = 3'd4;

  // Reset values
  localparam logic [14:0] MAX_ACCEL_RST      = 15'd1923;
  localparam logic [14:0] MAX_DECEL_RST      = 15'd2115;
  localparam logic [15:0] ACCEL_GAIN_RST     = 16'd549;
  localparam logic [14:0] MAX_STEER_RATE_RST = 15'd13107;
  localparam logic [9:0]  STEER_DEADBAND_RST = 10'd2;

  // Gain product is scaled down by 2^10
  localparam int GAIN_SHIFT = 10;

  typedef struct packed {
    logic signed [15:0] desired_speed;
    logic signed [15:0] desired_steer;
    logic signed [15:0] measured_speed;
    logic signed [15:0] measured_steer;
  } in_t;

  typedef struct packed {
    logic signed [15:0] accel_cmd;
    logic signed [15:0] steer_rate_cmd;
  } out_t;

endpackage

>>> design/drive_command_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// drive_command_rate_limiter_core
// Proportional speed controller with a delayed steering command.
//
//   channel | ports                        | payload
//   --------+------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data  | speeds and steering angles
//   output  | out_valid, out_stall, out_data | accel and steer-rate command
//   config  | cfg_we, cfg_idx, cfg_wdata   | five control registers
//
// One item per cycle sustained while the output is not stalled; a result
// passes through the stage 1 registers and the output register. Stage 1 does
// the gain multiply and the delay-line memory read/write; stage 2 clamps,
// selects and loads the output register. Reset is synchronous; it clears the
// pipeline valids, pointer and entry valids and loads the register reset values.
// in_stall is high throughout reset; after that it rises only when both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module drive_command_rate_limiter_core #(
  parameter int DELAY_DEPTH = dcrl_pkg::DELAY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dcrl_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dcrl_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [dcrl_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dcrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  // Control registers
  logic [14:0] max_accel_r;
  logic [14:0] max_decel_r;
  logic [15:0] accel_gain_r;
  logic [14:0] max_steer_rate_r;
  logic [9:0]  steer_deadband_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r      <= dcrl_pkg::MAX_ACCEL_RST;
      max_decel_r      <= dcrl_pkg::MAX_DECEL_RST;
      accel_gain_r     <= dcrl_pkg::ACCEL_GAIN_RST;
      max_steer_rate_r <= dcrl_pkg::MAX_STEER_RATE_RST;
      steer_deadband_r <= dcrl_pkg::STEER_DEADBAND_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dcrl_pkg::REG_MAX_ACCEL:      max_accel_r      <= cfg_wdata[14:0];
        dcrl_pkg::REG_MAX_DECEL:      max_decel_r      <= cfg_wdata[14:0];
        dcrl_pkg::REG_ACCEL_GAIN:     accel_gain_r     <= cfg_wdata[15:0];
        dcrl_pkg::REG_MAX_STEER_RATE: max_steer_rate_r <= cfg_wdata[14:0];
        dcrl_pkg::REG_STEER_DEADBAND: steer_deadband_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic s1_vld_r, s1_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic in_xfer, advance;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = !rst_n || (s1_vld_r && !advance);
  assign in_xfer  = in_valid && !in_stall;

  // Delay line pointer
  logic [PTR_W-1:0] ptr_r, ptr_nxt;

  always_comb begin
    ptr_nxt = ptr_r;
    if (in_xfer) begin
      if (ptr_r == PTR_W'(DELAY_DEPTH - 1)) ptr_nxt = '0;
      else                                  ptr_nxt = ptr_r + PTR_W'(1);
    end
  end

  logic signed [15:0] delayed;

  dcrl_steer_mem #(
    .DEPTH (DELAY_DEPTH),
    .PTR_W (PTR_W)
  ) u_steer_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (in_xfer),
    .ptr    (ptr_r),
    .wdata  (in_data.desired_steer),
    .rdata  (delayed)
  );

  // Stage 1: speed error and gain product
  logic signed [16:0] err;
  logic signed [33:0] prod;
  logic signed [33:0] prod_r;
  logic               err_pos_r;
  logic               mspd_pos_r;
  logic               mspd_neg_r;
  logic signed [15:0] msteer_r;

  assign err  = {in_data.desired_speed[15], in_data.desired_speed}
              - {in_data.measured_speed[15], in_data.measured_speed};
  assign prod = err * $signed({1'b0, accel_gain_r});

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prod_r     <= prod;
      err_pos_r  <= !err[16] && (err != 17'sd0);
      mspd_pos_r <= !in_data.measured_speed[15] && (in_data.measured_speed != 16'sd0);
      mspd_neg_r <= in_data.measured_speed[15];
      msteer_r   <= in_data.measured_steer;
    end
  end

  // Stage 2: clamp, braking select, steering deadband
  logic signed [33:0] p_shr;
  logic signed [33:0] lim;
  logic signed [15:0] p_clamp;
  logic signed [15:0] acc;
  logic signed [16:0] d;
  logic        [16:0] mag;
  logic signed [15:0] rate;
  dcrl_pkg::out_t     res;

  assign p_shr = prod_r >>> dcrl_pkg::GAIN_SHIFT;  // floor
  assign lim   = $signed({19'd0, max_accel_r});

  always_comb begin
    if (p_shr > lim)       p_clamp = $signed({1'b0, max_accel_r});
    else if (p_shr < -lim) p_clamp = -$signed({1'b0, max_accel_r});
    else                   p_clamp = p_shr[15:0];

    // Moving forward, a non-positive error brakes at full rate; moving backward, a positive error does
    if (mspd_pos_r)      acc = err_pos_r ? p_clamp : -$signed({1'b0, max_decel_r});
    else if (mspd_neg_r) acc = err_pos_r ? $signed({1'b0, max_decel_r}) : p_clamp;
    else                 acc = p_clamp;
  end

  assign d   = {delayed[15], delayed} - {msteer_r[15], msteer_r};
  assign mag = d[16] ? 17'(-d) : 17'(d);

  always_comb begin
    if (mag > {7'd0, steer_deadband_r})
      rate = d[16] ? -$signed({1'b0, max_steer_rate_r}) : $signed({1'b0, max_steer_rate_r});
    else
      rate = 16'sd0;
    res.accel_cmd      = acc;
    res.steer_rate_cmd = rate;
  end

  // Pipeline valids
  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = s1_vld_r;
      s1_vld_nxt  = 1'b0;
    end
    if (in_xfer) s1_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ptr_r     <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

  dcrl_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

>>> design/dcrl_steer_mem.sv
// ----------------------------------------------------------------------------
// dcrl_steer_mem
// Steering delay line held as a circular buffer in a synchronous memory.
// Read-first: the entry leaving the line is read while the new angle is
// written at the same address. Per-entry valid bits make unwritten entries
// read as zero after reset.
// ----------------------------------------------------------------------------
module dcrl_steer_mem #(
  parameter int DEPTH = dcrl_pkg::DELAY_DEPTH_DEF,
  parameter int PTR_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc_en,
  input  logic [PTR_W-1:0]    ptr,
  input  logic signed [15:0]  wdata,
  output logic signed [15:0]  rdata
);

  logic signed [15:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic signed [15:0] rd_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (acc_en) begin
      rd_r     <= mem[ptr];
      mem[ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else if (acc_en) begin
      rd_vld_r       <= valid_r[ptr];
      valid_r[ptr]   <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_r : 16'sd0;

endmodule

>>> design/dcrl_checker.sv
// ----------------------------------------------------------------------------
// dcrl_checker
// Port-level checks of the drive command rate limiter, bound to the top.
// ----------------------------------------------------------------------------
`include "drive_command_rate_limiter_core_assert.svh"

module dcrl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input dcrl_pkg::out_t out_data
);

  // A result held by the receiver stays put
  `DCRL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Input side only backs up when the result register is full and stalled
  `DCRL_ASSERT_IMP(a_in_stall_cause, in_stall, out_valid && out_stall)

  // Every fresh result traces back to an earlier input transfer
  `DCRL_ASSERT_IMP(a_out_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

  // Reset empties the pipeline
  `DCRL_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind drive_command_rate_limiter_core dcrl_checker u_dcrl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
